FILE: src/pump_run_idle_watchdog_assert.svh
// Assertion macros shared by the watchdog RTL.
// Each macro checks a property sampled on clk and switched off while rst is high.
`ifndef PUMP_RUN_IDLE_WATCHDOG_ASSERT_SVH
`define PUMP_RUN_IDLE_WATCHDOG_ASSERT_SVH

`ifndef SYNTHESIS

`define PRW_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("watchdog assertion failed");

`define PRW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("watchdog assertion failed");

`else

`define PRW_ASSERT_SAME(label, ante, cons)

`define PRW_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: src/prw_pkg.sv
`default_nettype none

package prw_pkg;

  localparam int SEC_W = 23;
  typedef logic [SEC_W-1:0] sec_t;

  localparam sec_t SEC_MAX = 23'h7F_FFFF;

  // 2^23 seconds in milliseconds: any span at or above this saturates.
  localparam logic [63:0] SAT_MS = 64'd8388608000;

  // Milliseconds to seconds: ms / 1000 = (ms / 8) / 125, and the division by
  // 125 of a 30-bit value is exact as a multiply by ceil(2^37 / 125) >> 37.
  localparam int EIGHTHS_W = 30;
  localparam int RECIP_W   = 31;
  localparam int PROD_W    = EIGHTHS_W + RECIP_W;
  localparam int RECIP_SH  = 37;
  localparam logic [RECIP_W-1:0] RECIP_125 = 31'd1099511628;

  localparam int MS_PER_S = 1000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t IDX_ON_TIMEOUT  = 3'd0;
  localparam cfg_idx_t IDX_OFF_TIMEOUT = 3'd1;
  localparam cfg_idx_t IDX_REPORT      = 3'd2;
  localparam cfg_idx_t IDX_THRESHOLD   = 3'd3;
  localparam cfg_idx_t IDX_REPEAT      = 3'd4;
  localparam cfg_idx_t IDX_CAP         = 3'd5;

  localparam logic [11:0] ON_TIMEOUT_RST  = 12'd600;
  localparam logic [20:0] OFF_TIMEOUT_RST = 21'd86400;
  localparam logic [15:0] THRESHOLD_RST   = 16'd10;
  localparam logic [31:0] REPEAT_RST      = 32'd600000;
  localparam logic [3:0]  CAP_RST         = 4'd10;

  // Timeout limits held in milliseconds: seconds > T exactly when ms > T*1000+999.
  localparam int ON_LIM_W  = 22;
  localparam int OFF_LIM_W = 31;
  localparam logic [ON_LIM_W-1:0]  ON_LIM_RST  = 22'd600999;
  localparam logic [OFF_LIM_W-1:0] OFF_LIM_RST = 31'd86400999;

  localparam int OUT_W = 104;

endpackage

`default_nettype wire

FILE: src/pump_run_idle_watchdog.sv
`default_nettype none

// Pump run/idle watchdog. Each input transaction closes one counting window
// (time stamp now_ms in the low TIME_WIDTH bits of s_axis_tdata, pulse_count
// above it); the pump is running when the count exceeds pulse_threshold, and
// every window gives exactly one result transaction with the running state,
// the length of a phase that just ended, the time spent in the current phase,
// overlong-phase alerts and the longest run and idle phases, all in whole
// seconds saturating at 8388607. The block takes one transaction per clock
// cycle; the whole pipeline holds while a result waits on m_axis_tready. A
// window passes an input register, the phase and alert register, the
// millisecond-to-second multiply register and the output register. The user
// must write configuration registers through cfg_we/cfg_index/cfg_data only
// while no window is in flight; the block does not enforce this. Writing a
// different timeout clears the matching longest-phase figure.
module pump_run_idle_watchdog #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // now_ms [TIME_WIDTH-1:0], pulse_count [TIME_WIDTH+15:TIME_WIDTH], zero pad above
  input  wire logic [((TIME_WIDTH + 23) / 8) * 8 - 1:0] s_axis_tdata,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // pump_running [0], changed [1], report [2], ended_phase_s [25:3], alert [26],
  // alert_for_running [27], elapsed_s [50:28], longest_run_s [73:51],
  // longest_idle_s [96:74], zero pad [103:97]
  output logic [prw_pkg::OUT_W-1:0]                  m_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  input  wire logic                                  cfg_we,
  input  wire prw_pkg::cfg_idx_t                     cfg_index,
  input  wire logic [prw_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = (TW > 32) ? TW : 32;

  // Configuration.
  logic [11:0]                     on_timeout_s;
  logic [20:0]                     off_timeout_s;
  logic                            report_changes;
  logic [15:0]                     pulse_threshold;
  logic [31:0]                     alert_repeat_ms;
  logic [3:0]                      alert_cap;
  logic [prw_pkg::ON_LIM_W-1:0]    on_lim_ms;
  logic [prw_pkg::OFF_LIM_W-1:0]   off_lim_ms;
  logic                            clr_run;
  logic                            clr_idle;

  // Pipeline control and payload.
  logic          adv;
  logic          step;
  logic          out_step;
  logic          v1, v2, v3;
  logic [TW-1:0] in_now;
  logic [15:0]   in_pulses;
  logic          s2_running, s2_changed, s2_report, s2_alert;
  logic [TW-1:0] s2_ended_ms, s2_elapsed_ms;
  logic          s3_running, s3_changed, s3_report, s3_alert;

  // Phase state.
  logic          running;
  logic [TW-1:0] run_start_ms, idle_start_ms;
  logic [TW-1:0] last_run_alert_ms, last_idle_alert_ms;
  logic          run_alert_seen, idle_alert_seen;
  logic [3:0]    run_alert_count, idle_alert_count;
  prw_pkg::sec_t max_run_s, max_idle_s;

  // Phase logic.
  logic          next_run;
  logic          chg;
  logic [TW-1:0] ended_ms_c, start_c, elapsed_c, last_c, since_c;
  logic          seen_c;
  logic [3:0]    count_c;
  logic          over_c, spaced_c, alert_c;

  prw_pkg::sec_t ended_s, elapsed_s, max_run_next, max_idle_next;

  // Output register.
  logic          out_valid;
  logic          o_running, o_changed, o_report, o_alert, o_alert_run;
  prw_pkg::sec_t o_ended_s, o_elapsed_s, o_longest_run_s, o_longest_idle_s;

  // ---------------------------------------------------------------- config
  assign clr_run  = cfg_we && (cfg_index == prw_pkg::IDX_ON_TIMEOUT) &&
                    (cfg_data[11:0] != on_timeout_s);
  assign clr_idle = cfg_we && (cfg_index == prw_pkg::IDX_OFF_TIMEOUT) &&
                    (cfg_data[20:0] != off_timeout_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      on_timeout_s    <= prw_pkg::ON_TIMEOUT_RST;
      off_timeout_s   <= prw_pkg::OFF_TIMEOUT_RST;
      report_changes  <= 1'b0;
      pulse_threshold <= prw_pkg::THRESHOLD_RST;
      alert_repeat_ms <= prw_pkg::REPEAT_RST;
      alert_cap       <= prw_pkg::CAP_RST;
      on_lim_ms       <= prw_pkg::ON_LIM_RST;
      off_lim_ms      <= prw_pkg::OFF_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        prw_pkg::IDX_ON_TIMEOUT: begin
          on_timeout_s <= cfg_data[11:0];
          on_lim_ms    <= prw_pkg::ON_LIM_W'(cfg_data[11:0]) *
                          prw_pkg::ON_LIM_W'(prw_pkg::MS_PER_S) +
                          prw_pkg::ON_LIM_W'(prw_pkg::MS_PER_S - 1);
        end
        prw_pkg::IDX_OFF_TIMEOUT: begin
          off_timeout_s <= cfg_data[20:0];
          off_lim_ms    <= prw_pkg::OFF_LIM_W'(cfg_data[20:0]) *
                           prw_pkg::OFF_LIM_W'(prw_pkg::MS_PER_S) +
                           prw_pkg::OFF_LIM_W'(prw_pkg::MS_PER_S - 1);
        end
        prw_pkg::IDX_REPORT:    report_changes  <= cfg_data[0];
        prw_pkg::IDX_THRESHOLD: pulse_threshold <= cfg_data[15:0];
        prw_pkg::IDX_REPEAT:    alert_repeat_ms <= cfg_data[31:0];
        prw_pkg::IDX_CAP:       alert_cap       <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // -------------------------------------------------------------- pipeline
  // The stages move together; a held result stops the whole pipeline.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;
  assign step          = adv && v1;
  assign out_step      = adv && v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= s_axis_tvalid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_now    <= s_axis_tdata[TW-1:0];
      in_pulses <= s_axis_tdata[TW +: 16];
    end
  end

  // ----------------------------------------------------------- phase logic
  assign next_run   = in_pulses > pulse_threshold;
  assign chg        = next_run != running;
  assign ended_ms_c = next_run ? (in_now - idle_start_ms) : (in_now - run_start_ms);
  assign start_c    = chg ? in_now : (next_run ? run_start_ms : idle_start_ms);
  assign elapsed_c  = in_now - start_c;
  assign last_c     = next_run ? last_run_alert_ms : last_idle_alert_ms;
  assign since_c    = in_now - last_c;
  assign seen_c     = !chg && (next_run ? run_alert_seen : idle_alert_seen);
  assign count_c    = chg ? 4'd0 : (next_run ? run_alert_count : idle_alert_count);
  assign over_c     = next_run ? (CW'(elapsed_c) > CW'(on_lim_ms))
                               : (CW'(elapsed_c) > CW'(off_lim_ms));
  assign spaced_c   = !seen_c || (CW'(since_c) > CW'(alert_repeat_ms));
  assign alert_c    = over_c && (count_c < alert_cap) && spaced_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      running            <= 1'b0;
      run_start_ms       <= '0;
      idle_start_ms      <= '0;
      last_run_alert_ms  <= '0;
      last_idle_alert_ms <= '0;
      run_alert_seen     <= 1'b0;
      idle_alert_seen    <= 1'b0;
      run_alert_count    <= 4'd0;
      idle_alert_count   <= 4'd0;
    end else if (step) begin
      running <= next_run;
      if (next_run) begin
        if (chg) begin
          run_start_ms <= in_now;
        end
        if (alert_c) begin
          last_run_alert_ms <= in_now;
        end
        run_alert_seen  <= seen_c || alert_c;
        run_alert_count <= alert_c ? count_c + 4'd1 : count_c;
      end else begin
        if (chg) begin
          idle_start_ms <= in_now;
        end
        if (alert_c) begin
          last_idle_alert_ms <= in_now;
        end
        idle_alert_seen  <= seen_c || alert_c;
        idle_alert_count <= alert_c ? count_c + 4'd1 : count_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_running    <= next_run;
      s2_changed    <= chg;
      s2_report     <= chg && report_changes;
      s2_alert      <= alert_c;
      s2_ended_ms   <= chg ? ended_ms_c : '0;
      s2_elapsed_ms <= elapsed_c;
      s3_running    <= s2_running;
      s3_changed    <= s2_changed;
      s3_report     <= s2_report;
      s3_alert      <= s2_alert;
    end
  end

  // ------------------------------------------------------ seconds and maxima
  prw_ms_to_s #(.TIME_WIDTH(TW)) u_ended_conv (
    .clk (clk),
    .en  (adv),
    .ms  (s2_ended_ms),
    .sec (ended_s)
  );

  prw_ms_to_s #(.TIME_WIDTH(TW)) u_elapsed_conv (
    .clk (clk),
    .en  (adv),
    .ms  (s2_elapsed_ms),
    .sec (elapsed_s)
  );

  // A change into running ends an idle phase, and the other way round.
  assign max_run_next  = (s3_changed && !s3_running && (ended_s > max_run_s))
                         ? ended_s : max_run_s;
  assign max_idle_next = (s3_changed && s3_running && (ended_s > max_idle_s))
                         ? ended_s : max_idle_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_run_s  <= '0;
      max_idle_s <= '0;
    end else if (clr_run || clr_idle) begin
      if (clr_run) begin
        max_run_s <= '0;
      end
      if (clr_idle) begin
        max_idle_s <= '0;
      end
    end else if (out_step) begin
      max_run_s  <= max_run_next;
      max_idle_s <= max_idle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_running        <= s3_running;
      o_changed        <= s3_changed;
      o_report         <= s3_report;
      o_ended_s        <= ended_s;
      o_alert          <= s3_alert;
      o_alert_run      <= s3_alert && s3_running;
      o_elapsed_s      <= elapsed_s;
      o_longest_run_s  <= max_run_next;
      o_longest_idle_s <= max_idle_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, o_longest_idle_s, o_longest_run_s, o_elapsed_s,
                          o_alert_run, o_alert, o_ended_s, o_report, o_changed,
                          o_running};

  // ------------------------------------------------------------ assertions
`include "pump_run_idle_watchdog_assert.svh"

  `PRW_ASSERT_SAME(a_alert_needs_time, out_valid && o_alert, o_elapsed_s != '0)
  `PRW_ASSERT_SAME(a_change_restarts, out_valid && o_changed, o_elapsed_s == '0)
  `PRW_ASSERT_SAME(a_run_max_covers, out_valid && o_changed && !o_running,
                   o_longest_run_s >= o_ended_s)
  `PRW_ASSERT_NEXT(a_run_start_taken, step && chg && next_run,
                   run_start_ms == $past(in_now))

endmodule

`default_nettype wire

FILE: src/prw_ms_to_s.sv
`default_nettype none

module prw_ms_to_s #(
  parameter int TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [TIME_WIDTH-1:0] ms,
  output prw_pkg::sec_t              sec
);

  localparam int XW = (TIME_WIDTH > 34) ? TIME_WIDTH : 34;

  logic [XW-1:0]                       ms_x;
  logic                                over;
  logic [prw_pkg::EIGHTHS_W-1:0]       eighths;
  logic [prw_pkg::PROD_W-1:0]          prod;
  logic                                over_q;

  assign ms_x    = XW'(ms);
  assign over    = ms_x >= XW'(prw_pkg::SAT_MS);
  assign eighths = ms_x[prw_pkg::EIGHTHS_W+2:3];

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= prw_pkg::PROD_W'(eighths) * prw_pkg::PROD_W'(prw_pkg::RECIP_125);
      over_q <= over;
    end
  end

  assign sec = over_q ? prw_pkg::SEC_MAX
                      : prod[prw_pkg::RECIP_SH+prw_pkg::SEC_W-1:prw_pkg::RECIP_SH];

endmodule

`default_nettype wire

FILE: bench/pump_window_checker.sv
`timescale 1ns / 100ps

// Watches the window and result channels and the register port, predicts the
// result of every accepted window and compares each result transaction with
// the oldest prediction.
module pump_window_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [47:0]            s_tdata,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [103:0]           m_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic                   cfg_we,
  input  prw_pkg::cfg_idx_t      cfg_index,
  input  logic [31:0]            cfg_data,
  output int                     fail_count,
  output int                     windows_waiting
);

  // Packed so that the first field of the result lands in the lowest bits.
  typedef struct packed {
    prw_pkg::sec_t longest_idle;
    prw_pkg::sec_t longest_run;
    prw_pkg::sec_t elapsed;
    logic          alert_run;
    logic          alert;
    prw_pkg::sec_t ended;
    logic          report;
    logic          changed;
    logic          running;
  } window_res_t;

  // Register copies.
  logic [11:0] on_limit_s;
  logic [20:0] off_limit_s;
  logic        flag_changes;
  logic [15:0] thr;
  logic [31:0] repeat_gap;
  logic [3:0]  max_alerts;

  // Phase tracking.
  logic          is_running;
  logic [31:0]   run_t0, idle_t0;
  prw_pkg::sec_t top_run, top_idle;
  logic [31:0]   run_alert_t, idle_alert_t;
  logic          run_alerted, idle_alerted;
  logic [3:0]    run_alerts, idle_alerts;

  window_res_t window_reports[$];

  function automatic logic [31:0] secs_since(logic [31:0] t0, logic [31:0] t);
    logic [31:0] span;
    span = t - t0;
    return span / 32'(prw_pkg::MS_PER_S);
  endfunction

  function automatic prw_pkg::sec_t clip_secs(logic [31:0] s);
    return (s > 32'(prw_pkg::SEC_MAX)) ? prw_pkg::SEC_MAX : s[prw_pkg::SEC_W-1:0];
  endfunction

  task automatic reset_model();
    on_limit_s   = prw_pkg::ON_TIMEOUT_RST;
    off_limit_s  = prw_pkg::OFF_TIMEOUT_RST;
    flag_changes = 1'b0;
    thr          = prw_pkg::THRESHOLD_RST;
    repeat_gap   = prw_pkg::REPEAT_RST;
    max_alerts   = prw_pkg::CAP_RST;
    is_running   = 1'b0;
    run_t0       = '0;
    idle_t0      = '0;
    top_run      = '0;
    top_idle     = '0;
    run_alert_t  = '0;
    idle_alert_t = '0;
    run_alerted  = 1'b0;
    idle_alerted = 1'b0;
    run_alerts   = '0;
    idle_alerts  = '0;
  endtask

  task automatic write_register(prw_pkg::cfg_idx_t idx, logic [31:0] d);
    case (idx)
      prw_pkg::IDX_ON_TIMEOUT: begin
        if (d[11:0] != on_limit_s) begin
          on_limit_s = d[11:0];
          top_run = '0;
        end
      end
      prw_pkg::IDX_OFF_TIMEOUT: begin
        if (d[20:0] != off_limit_s) begin
          off_limit_s = d[20:0];
          top_idle = '0;
        end
      end
      prw_pkg::IDX_REPORT:    flag_changes = d[0];
      prw_pkg::IDX_THRESHOLD: thr = d[15:0];
      prw_pkg::IDX_REPEAT:    repeat_gap = d;
      prw_pkg::IDX_CAP:       max_alerts = d[3:0];
      default: ;
    endcase
  endtask

  task automatic close_window(input logic [31:0] t, input logic [15:0] p,
                              output window_res_t r);
    logic        nxt;
    logic [31:0] ended;
    logic [31:0] elapsed;
    r = '0;
    ended = '0;
    nxt = p > thr;
    r.changed = nxt != is_running;
    if (r.changed) begin
      if (nxt) begin
        ended = secs_since(idle_t0, t);
        if (clip_secs(ended) > top_idle) top_idle = clip_secs(ended);
        run_t0 = t;
        run_alerted = 1'b0;
        run_alerts = '0;
      end else begin
        ended = secs_since(run_t0, t);
        if (clip_secs(ended) > top_run) top_run = clip_secs(ended);
        idle_t0 = t;
        idle_alerted = 1'b0;
        idle_alerts = '0;
      end
      is_running = nxt;
    end
    // Timeout compares use the unclipped second count.
    if (is_running) begin
      elapsed = secs_since(run_t0, t);
      if (elapsed > 32'(on_limit_s) && run_alerts < max_alerts &&
          (!run_alerted || (t - run_alert_t) > repeat_gap)) begin
        r.alert = 1'b1;
        run_alert_t = t;
        run_alerted = 1'b1;
        run_alerts = run_alerts + 4'd1;
      end
    end else begin
      elapsed = secs_since(idle_t0, t);
      if (elapsed > 32'(off_limit_s) && idle_alerts < max_alerts &&
          (!idle_alerted || (t - idle_alert_t) > repeat_gap)) begin
        r.alert = 1'b1;
        idle_alert_t = t;
        idle_alerted = 1'b1;
        idle_alerts = idle_alerts + 4'd1;
      end
    end
    r.running      = is_running;
    r.report       = r.changed & flag_changes;
    r.ended        = clip_secs(ended);
    r.alert_run    = r.alert & is_running;
    r.elapsed      = clip_secs(elapsed);
    r.longest_run  = top_run;
    r.longest_idle = top_idle;
  endtask

  task automatic check_field(string name, logic [22:0] want, logic [22:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    window_res_t want, got;
    if (rst) begin
      reset_model();
      window_reports.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        close_window(s_tdata[31:0], s_tdata[47:32], want);
        window_reports.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = window_res_t'(m_tdata[96:0]);
        if (window_reports.size() == 0) begin
          $display("%0t: result transaction with no window waiting, got %h", $time, m_tdata);
          fail_count++;
        end else begin
          want = window_reports.pop_front();
          check_field("pump_running", 23'(want.running), 23'(got.running));
          check_field("changed", 23'(want.changed), 23'(got.changed));
          check_field("report", 23'(want.report), 23'(got.report));
          check_field("ended_phase_s", want.ended, got.ended);
          check_field("alert", 23'(want.alert), 23'(got.alert));
          check_field("alert_for_running", 23'(want.alert_run), 23'(got.alert_run));
          check_field("elapsed_s", want.elapsed, got.elapsed);
          check_field("longest_run_s", want.longest_run, got.longest_run);
          check_field("longest_idle_s", want.longest_idle, got.longest_idle);
        end
      end
    end
    windows_waiting = window_reports.size();
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int                IDLE_LIMIT = 4000;
  localparam int                LONG_HOLD  = 120;
  localparam prw_pkg::cfg_idx_t IDX_SPARE  = prw_pkg::IDX_CAP + 3'd1;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic [47:0]       s_axis_tdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [103:0]      m_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic              cfg_we = 1'b0;
  prw_pkg::cfg_idx_t cfg_index = prw_pkg::IDX_ON_TIMEOUT;
  logic [31:0]       cfg_data = '0;

  int check_fails;
  int windows_waiting;

  // Stimulus shaping.
  int          gap_pct = 20;
  int          stall_pct = 20;
  logic [31:0] now_t = '0;
  logic [15:0] cur_thr = prw_pkg::THRESHOLD_RST;
  logic [11:0] cur_on = prw_pkg::ON_TIMEOUT_RST;
  bit          want_run = 1'b0;
  int          run_left = 0;

  pump_run_idle_watchdog #(.TIME_WIDTH(32)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pump_window_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tdata         (s_axis_tdata),
    .s_tvalid        (s_axis_tvalid),
    .s_tready        (s_axis_tready),
    .m_tdata         (m_axis_tdata),
    .m_tvalid        (m_axis_tvalid),
    .m_tready        (m_axis_tready),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (check_fails),
    .windows_waiting (windows_waiting)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result sink: short random stalls, plus one long hold in the middle of a
  // stream once a couple of hundred results have gone by, so that the
  // pipeline fills and backs up.
  int  stall_left = 0;
  int  results_seen = 0;
  bit  long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) results_seen++;
    if (!long_hold_done && results_seen >= 230) begin
      long_hold_done = 1'b1;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(1, 4);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Ends the run if nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_window(logic [31:0] t, logic [15:0] p);
    s_axis_tdata  <= {p, t};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (windows_waiting != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // The caller lowers cfg_we after its last write.
  task automatic write_reg(prw_pkg::cfg_idx_t idx, logic [31:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    if (idx == prw_pkg::IDX_THRESHOLD) cur_thr = d[15:0];
    if (idx == prw_pkg::IDX_ON_TIMEOUT) cur_on = d[11:0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pulses(bit run);
    int thr_i, lo, hi;
    thr_i = int'(cur_thr);
    if (run && thr_i < 65535) begin
      lo = thr_i + 1;
      hi = (thr_i + 64 > 65535) ? 65535 : thr_i + 64;
      case ($urandom_range(9))
        0:       return 16'(lo);
        1:       return 16'($urandom_range(65535, lo));
        default: return 16'($urandom_range(hi, lo));
      endcase
    end
    lo = (thr_i > 64) ? thr_i - 64 : 0;
    case ($urandom_range(9))
      0:       return 16'(thr_i);
      1:       return 16'($urandom_range(thr_i, 0));
      default: return 16'($urandom_range(thr_i, lo));
    endcase
  endfunction

  // Mostly runs of windows in one state with plausible time steps; a few
  // windows carry arbitrary time stamps and counts.
  task automatic send_stream(int n);
    int          k;
    logic [31:0] step;
    repeat (n) begin
      if ($urandom_range(99) < 8) begin
        send_window($urandom, 16'($urandom));
      end else begin
        if (run_left == 0) begin
          if ($urandom_range(4) != 0) want_run = !want_run;
          run_left = $urandom_range(1, 12);
        end
        run_left--;
        k = $urandom_range(99);
        if (k < 65)      step = $urandom_range(1500, 0);
        else if (k < 88) step = $urandom_range(60000, 0);
        else if (k < 97) step = $urandom_range(3000000, 0);
        else             step = $urandom;
        now_t = now_t + step;
        send_window(now_t, pick_pulses(want_run));
      end
    end
  endtask

  task automatic random_config();
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(3) == 0) write_reg(prw_pkg::IDX_ON_TIMEOUT, 32'(cur_on));
      else if ($urandom_range(3) == 0) begin
        write_reg(prw_pkg::IDX_ON_TIMEOUT, $urandom_range(3599, 0));
      end else write_reg(prw_pkg::IDX_ON_TIMEOUT, $urandom_range(20, 0));
    end
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(3) == 0) begin
        write_reg(prw_pkg::IDX_OFF_TIMEOUT, $urandom_range(1292400, 0));
      end else write_reg(prw_pkg::IDX_OFF_TIMEOUT, $urandom_range(40, 0));
    end
    write_reg(prw_pkg::IDX_REPORT, $urandom_range(1, 0));
    if ($urandom_range(3) == 0) write_reg(prw_pkg::IDX_THRESHOLD, $urandom_range(65535, 0));
    else write_reg(prw_pkg::IDX_THRESHOLD, $urandom_range(100, 0));
    if ($urandom_range(4) == 0) begin
      write_reg(prw_pkg::IDX_REPEAT, $urandom_range(32'hFFFF_FFFF, 1));
    end else write_reg(prw_pkg::IDX_REPEAT, $urandom_range(5000, 1));
    write_reg(prw_pkg::IDX_CAP, $urandom_range(15, 0));
    write_reg(IDX_SPARE + 3'($urandom_range(1, 0)), $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first idle phase timed from zero, threshold boundary,
    // strict timeout and strict repeat spacing, idle timeout, wrapping time.
    send_window(32'd0, 16'd0);
    send_window(32'd500, 16'd10);
    send_window(32'd1000, 16'd11);
    send_window(32'd601999, 16'hFFFF);
    send_window(32'd602000, 16'hFFFF);
    send_window(32'd1202000, 16'd11);
    send_window(32'd1202001, 16'd11);
    send_window(32'd1202500, 16'd0);
    send_window(32'd87603500, 16'd5);
    send_window(32'hFFFF_FC18, 16'd20);
    send_window(32'd500, 16'd20);
    send_window(32'hFFFF_FFFF, 16'd0);
    wait_quiet();

    // Alert cap reached within a phase, zero timeouts.
    write_reg(prw_pkg::IDX_ON_TIMEOUT, 32'd0);
    write_reg(prw_pkg::IDX_OFF_TIMEOUT, 32'd0);
    write_reg(prw_pkg::IDX_REPORT, 32'd1);
    write_reg(prw_pkg::IDX_REPEAT, 32'd1000);
    write_reg(prw_pkg::IDX_CAP, 32'd2);
    cfg_we <= 1'b0;
    send_window(32'd5000, 16'd100);
    send_window(32'd6500, 16'd100);
    send_window(32'd8000, 16'd100);
    send_window(32'd9500, 16'd100);
    send_window(32'd10000, 16'd0);
    send_window(32'd11000, 16'd0);
    wait_quiet();

    // Cap zero silences alerts; an unchanged timeout keeps its maximum and
    // writes to unused indexes have no effect.
    write_reg(prw_pkg::IDX_CAP, 32'd0);
    write_reg(prw_pkg::IDX_ON_TIMEOUT, 32'd0);
    write_reg(IDX_SPARE, 32'hFFFF_FFFF);
    write_reg(IDX_SPARE + 3'd1, 32'd0);
    cfg_we <= 1'b0;
    send_window(32'd20000, 16'd0);
    send_window(32'd30000, 16'd200);
    send_window(32'd45000, 16'd200);
    send_window(32'd60000, 16'd0);
    now_t = 32'd60000;

    for (int ph = 0; ph < 10; ph++) begin
      wait_quiet();
      if (ph == 0) begin
        write_reg(prw_pkg::IDX_ON_TIMEOUT, 32'd0);
        write_reg(prw_pkg::IDX_OFF_TIMEOUT, 32'd0);
        write_reg(prw_pkg::IDX_REPORT, 32'd1);
        write_reg(prw_pkg::IDX_THRESHOLD, 32'd0);
        write_reg(prw_pkg::IDX_REPEAT, 32'd1);
        write_reg(prw_pkg::IDX_CAP, 32'd15);
        cfg_we <= 1'b0;
      end else if (ph == 1) begin
        write_reg(prw_pkg::IDX_ON_TIMEOUT, 32'd3599);
        write_reg(prw_pkg::IDX_OFF_TIMEOUT, 32'd1292400);
        write_reg(prw_pkg::IDX_REPORT, 32'd0);
        write_reg(prw_pkg::IDX_THRESHOLD, 32'd65535);
        write_reg(prw_pkg::IDX_REPEAT, 32'hFFFF_FFFF);
        write_reg(prw_pkg::IDX_CAP, 32'd0);
        cfg_we <= 1'b0;
      end else begin
        random_config();
      end
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 30;
      endcase
      stall_pct = (ph == 4) ? 0 : $urandom_range(30, 5);
      // The closing part of the run has no idling on either side.
      if (ph == 9) begin
        gap_pct = 0;
        stall_pct = 0;
      end
      send_stream(140);
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (check_fails == 0 && windows_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
